/* hw/rtl/winding_span_builder_core_defines.svh */
// assertion macros for the winding span builder
// used by the top level, which supplies clk and rst in scope
`ifndef WINDING_SPAN_BUILDER_CORE_DEFINES_SVH
`define WINDING_SPAN_BUILDER_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define WSB_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, off during reset
`define WSB_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/wsb_pkg.sv */
// shared types and constants for the winding span builder
// no dependencies; imported by wsb_span_step and the top level
package wsb_pkg;

  localparam int CoordBits = 16;
  localparam int WindBits  = 16;
  localparam int DeltaBits = 8;

  localparam logic signed [CoordBits-1:0] RectLeftReset  = CoordBits'(0);
  localparam logic signed [CoordBits-1:0] RectRightReset = CoordBits'(1024);

  localparam logic signed [WindBits-1:0] WindMax = {1'b0, {(WindBits-1){1'b1}}};
  localparam logic signed [WindBits-1:0] WindMin = {1'b1, {(WindBits-1){1'b0}}};

  typedef enum logic {
    ModeEdge   = 1'b0,
    ModeEndRow = 1'b1
  } wsb_mode_t;

  typedef enum logic {
    CfgRectLeft  = 1'b0,
    CfgRectRight = 1'b1
  } wsb_cfg_idx_t;

  typedef struct packed {
    wsb_mode_t                     mode;
    logic signed [CoordBits-1:0]   edge_x;
    logic signed [DeltaBits-1:0]   winding_delta;
  } wsb_trans_t;

  typedef struct packed {
    logic signed [CoordBits-1:0] span_start;
    logic signed [CoordBits-1:0] span_end;
    logic                        closes_row;
  } wsb_span_t;

  typedef struct packed {
    logic signed [WindBits-1:0]  winding_total;
    logic                        covered;
    logic signed [CoordBits-1:0] span_begin;
    logic                        row_done;
  } wsb_state_t;

endpackage

/* hw/rtl/wsb_span_step.sv */
// next-state and span logic for one transition item
// depends on wsb_pkg
module wsb_span_step
  import wsb_pkg::*;
(
  input  wsb_state_t                  cur,
  input  wsb_trans_t                  item,
  input  logic signed [CoordBits-1:0] rect_left,
  input  logic signed [CoordBits-1:0] rect_right,
  output wsb_state_t                  nxt,
  output logic                        emit,
  output wsb_span_t                   span
);

  logic signed [CoordBits-1:0] x;
  logic signed [CoordBits-1:0] begin_x;
  logic signed [WindBits:0]    wind_sum;
  logic signed [WindBits-1:0]  wind_sat;

  assign x       = item.edge_x;
  assign begin_x = cur.span_begin;

  // widened add, saturate when the two top bits disagree
  always_comb begin
    wind_sum = {cur.winding_total[WindBits-1], cur.winding_total}
             + {{(WindBits+1-DeltaBits){item.winding_delta[DeltaBits-1]}},
                item.winding_delta};
    if (wind_sum[WindBits] != wind_sum[WindBits-1]) begin
      wind_sat = wind_sum[WindBits] ? WindMin : WindMax;
    end else begin
      wind_sat = wind_sum[WindBits-1:0];
    end
  end

  always_comb begin
    nxt             = cur;
    emit            = 1'b0;
    span.span_start = begin_x;
    span.span_end   = rect_right;
    span.closes_row = 1'b1;
    unique case (item.mode)
      ModeEndRow: begin
        emit              = !cur.row_done && cur.covered && (begin_x < rect_right);
        nxt.winding_total = '0;
        nxt.covered       = 1'b0;
        nxt.span_begin    = rect_left;
        nxt.row_done      = 1'b0;
      end
      ModeEdge: begin
        if (!cur.row_done && (item.winding_delta != '0)) begin
          if (x >= rect_right) begin
            // row closes at the right bound
            emit = cur.covered && (begin_x < x) && (begin_x < rect_right);
            nxt.row_done = 1'b1;
          end else begin
            emit              = cur.covered && (begin_x < x);
            span.span_end     = x;
            span.closes_row   = 1'b0;
            nxt.span_begin    = (x > rect_left) ? x : rect_left;
            nxt.winding_total = wind_sat;
            nxt.covered       = (wind_sat != '0);
          end
        end
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

endmodule

/* hw/rtl/winding_span_builder_core.sv */
// winding span builder top level: input register, step logic, result register
// depends on wsb_pkg, wsb_span_step and winding_span_builder_core_defines.svh
//
// usage
//   trans channel: x-sorted edge transitions of a scanline (mode edge) and an
//   end-of-row item (mode end row) closing each scanline; valid/stall
//   handshake, item taken at an edge with trans_valid high and trans_stall low
//   span channel: covered spans under the nonzero winding rule, clipped to
//   [rect_left, rect_right); at most one span per input item
//   config port: cfg_we with cfg_index 0 = rect_left, 1 = rect_right,
//   written in one cycle; write only while the block is idle
// timing
//   latency 1 cycle from input acceptance to a span on the output register
//   throughput 1 item per cycle, set by the single-cycle winding update and
//   the one-deep result register
// reset
//   rst clears both registers' valid flags and the row state; rect_left
//   returns to 0 and rect_right to 1024
// stall
//   while span_stall holds a pending span, the held input item waits and
//   trans_stall rises; an empty input register never stalls the sender
`include "winding_span_builder_core_defines.svh"

module winding_span_builder_core
  import wsb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // transition input channel
  input  logic                  trans_valid,
  output logic                  trans_stall,
  input  wsb_trans_t            trans_item,
  // span output channel
  output logic                  span_valid,
  input  logic                  span_stall,
  output wsb_span_t             span_item,
  // configuration writes
  input  logic                  cfg_we,
  input  wsb_cfg_idx_t          cfg_index,
  input  logic [CoordBits-1:0]  cfg_data
);

  // input register
  logic       stage_valid;
  wsb_trans_t stage_item;

  // clip bounds
  logic signed [CoordBits-1:0] rect_left;
  logic signed [CoordBits-1:0] rect_right;

  // row state
  wsb_state_t row_state;
  wsb_state_t row_state_next;

  logic       step_emit;
  wsb_span_t  step_span;
  logic       trans_accept;
  logic       advance;

  // the staged item moves on when the result register is free or being drained
  assign advance      = stage_valid && (!span_valid || !span_stall);
  assign trans_stall  = stage_valid && !advance;
  assign trans_accept = trans_valid && !trans_stall;

  wsb_span_step u_step (
    .cur        (row_state),
    .item       (stage_item),
    .rect_left  (rect_left),
    .rect_right (rect_right),
    .nxt        (row_state_next),
    .emit       (step_emit),
    .span       (step_span)
  );

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (trans_accept) begin
      stage_valid <= 1'b1;
    end else if (advance) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (trans_accept) begin
      stage_item <= trans_item;
    end
  end

  // row state and clip bounds; state only moves when an item is processed
  always_ff @(posedge clk) begin
    if (rst) begin
      rect_left                <= RectLeftReset;
      rect_right               <= RectRightReset;
      row_state.winding_total  <= '0;
      row_state.covered        <= 1'b0;
      row_state.span_begin     <= RectLeftReset;
      row_state.row_done       <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CfgRectLeft:  rect_left  <= cfg_data;
          CfgRectRight: rect_right <= cfg_data;
          default: ;
        endcase
      end
      if (advance) begin
        row_state <= row_state_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      span_valid <= 1'b0;
    end else if (advance) begin
      span_valid <= step_emit;
    end else if (span_valid && !span_stall) begin
      span_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && step_emit) begin
      span_item <= step_span;
    end
  end

  // checks
  `WSB_ASSERT_NOW(a_span_nonempty, span_valid,
    $signed(span_item.span_start) < $signed(span_item.span_end),
    "span emitted with start not below end")
  `WSB_ASSERT_NOW(a_covered_tracks_total, 1'b1,
    row_state.covered == (row_state.winding_total != '0),
    "covered flag disagrees with winding total")
  `WSB_ASSERT_NOW(a_empty_stage_no_stall, !stage_valid, !trans_stall,
    "input stalled with an empty input register")
  `WSB_ASSERT_NEXT(a_end_row_clears, advance && (stage_item.mode == ModeEndRow),
    !row_state.row_done && !row_state.covered && (row_state.winding_total == '0),
    "row state not cleared after end of row")

endmodule
